// ===== hdl/rbl_pkg.sv =====
`default_nettype none

package rbl_pkg;

    typedef logic [1:0]  t_mode;
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_frac2;
    typedef logic [24:0] t_num;

    localparam t_mode MODE_OVER  = 2'd0;
    localparam t_mode MODE_ADD   = 2'd1;
    localparam t_mode MODE_ERASE = 2'd2;

    localparam int NUM_COLOR = 3;
    localparam int NUM_LANES = 4;
    localparam int NUM_STAGES = 5;

    localparam t_frac2 FULL2 = 16'd65025;
    localparam t_num   FULL3 = 25'd16581375;
    localparam t_num   ROUND_BIAS = 25'd65025;
    localparam t_byte  ALPHA_SRC_FULL = 8'd255;
    localparam t_byte  ALPHA_SRC_NONE = 8'd0;

    localparam logic [16:0] DIV_D = 17'd130050;
    localparam logic [24:0] DIV_M = 25'd16909060;
    localparam int          DIV_SHIFT = 41;

endpackage

`default_nettype wire

// ===== hdl/rbl_if.sv =====
`default_nettype none

interface rbl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] coverage;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;

    modport source (
        output valid, src_red, src_green, src_blue, src_alpha, coverage,
               dst_red, dst_green, dst_blue, dst_alpha,
        input  ready
    );
    modport sink (
        input  valid, src_red, src_green, src_blue, src_alpha, coverage,
               dst_red, dst_green, dst_blue, dst_alpha,
        output ready
    );
endinterface

interface rbl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/rbl_lane.sv =====
`default_nettype none

module rbl_lane
    import rbl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_en,
    input  wire t_mode  i_mode,
    input  wire t_byte  i_src,
    input  wire t_byte  i_dst,
    input  wire t_frac2 i_alpha,
    input  wire t_frac2 i_inv,
    output t_num        o_num
);

    logic [23:0] w_src_term;
    logic [23:0] w_dst_term;
    t_num        n_num;
    t_num        r_num;

    always_comb begin
        case (i_mode)
            MODE_ADD: begin
                w_src_term = i_src * i_alpha;
                w_dst_term = i_dst * FULL2;
            end
            MODE_ERASE: begin
                w_src_term = '0;
                w_dst_term = i_dst * i_inv;
            end
            default: begin
                w_src_term = i_src * i_alpha;
                w_dst_term = i_dst * i_inv;
            end
        endcase
        n_num = {1'b0, w_src_term} + {1'b0, w_dst_term};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
        end
    end

    assign o_num = r_num;

endmodule

`default_nettype wire

// ===== hdl/rbl_merge.sv =====
`default_nettype none

module rbl_merge
    import rbl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire t_mode                i_mode,
    input  wire t_num [NUM_LANES-1:0] i_num,
    output t_num [NUM_LANES-1:0]      o_x
);

    t_num                 w_max01;
    t_num                 w_max;
    t_num [NUM_LANES-1:0] w_fixed;
    t_num [NUM_LANES-1:0] n_x;
    t_num [NUM_LANES-1:0] r_x;

    always_comb begin
        w_max01 = (i_num[0] > i_num[1]) ? i_num[0] : i_num[1];
        w_max   = (w_max01 > i_num[2]) ? w_max01 : i_num[2];
        w_fixed = i_num;
        if ((i_mode == MODE_ADD) && (i_num[NUM_COLOR] < w_max)) begin
            w_fixed[NUM_COLOR] = w_max;
        end
        for (int k = 0; k < NUM_LANES; k++) begin
            if (w_fixed[k] > FULL3) begin
                n_x[k] = {FULL3[23:0], 1'b0} + ROUND_BIAS;
            end else begin
                n_x[k] = {w_fixed[k][23:0], 1'b0} + ROUND_BIAS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
        end
    end

    assign o_x = r_x;

endmodule

`default_nettype wire

// ===== hdl/rbl_to_byte.sv =====
`default_nettype none

module rbl_to_byte
    import rbl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en_mul,
    input  wire logic i_en_fix,
    input  wire t_num i_x,
    output t_byte     o_byte
);

    // The reciprocal estimate is at most one below the true quotient.
    logic [49:0] w_prod;
    logic [8:0]  n_q0;
    logic [8:0]  r_q0;
    t_num        r_x;
    logic [25:0] w_qd;
    logic [25:0] w_rem;
    logic [8:0]  w_q;
    t_byte       r_byte;

    always_comb begin
        w_prod = i_x * DIV_M;
        n_q0   = w_prod[DIV_SHIFT +: 9];
    end

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_q0 <= n_q0;
            r_x  <= i_x;
        end
    end

    always_comb begin
        w_qd  = r_q0 * DIV_D;
        w_rem = {1'b0, r_x} - w_qd;
        w_q   = (w_rem >= {9'd0, DIV_D}) ? (r_q0 + 9'd1) : r_q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_fix) begin
            r_byte <= w_q[7:0];
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

// ===== hdl/rgba_pixel_blend_core.sv =====
// An accepted request passes through each pipeline stage in turn to the output.
// Throughput: one request per cycle while the output is not stalled; each
// pipeline stage holds only while the stage after it is full and stalled, so
// bubbles close up under stall. The depth is set by the alpha product, the
// lane multiply-add, the merge stage and the two-stage reciprocal divider.
// Reset clears all stage valid flags and returns the blend mode to source over.
`default_nettype none

module rgba_pixel_blend_core
    import rbl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire t_mode  i_cfg_data,
    rbl_in_if.sink      i_pix,
    rbl_out_if.source   o_res
);

    t_mode                    r_mode;
    logic [NUM_STAGES-1:0]    r_valid;
    logic [NUM_STAGES-1:0]    w_en;

    t_frac2                   r_alpha;
    t_frac2                   r_inv;
    t_byte [NUM_LANES-1:0]    r_src;
    t_byte [NUM_LANES-1:0]    r_dst;
    t_byte [NUM_LANES-1:0]    w_lane_src;
    t_frac2                   n_alpha;
    t_num  [NUM_LANES-1:0]    w_num;
    t_num  [NUM_LANES-1:0]    w_x;
    t_byte [NUM_LANES-1:0]    w_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OVER;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_comb begin
        w_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || o_res.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_pix.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign n_alpha = i_pix.src_alpha * i_pix.coverage;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_alpha <= n_alpha;
            r_inv   <= FULL2 - n_alpha;
            r_src   <= {8'd0, i_pix.src_blue, i_pix.src_green, i_pix.src_red};
            r_dst   <= {i_pix.dst_alpha, i_pix.dst_blue, i_pix.dst_green, i_pix.dst_red};
        end
    end

    always_comb begin
        w_lane_src = r_src;
        w_lane_src[NUM_COLOR] = (r_mode == MODE_ADD) ? ALPHA_SRC_NONE : ALPHA_SRC_FULL;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rbl_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en[1]),
            .i_mode  (r_mode),
            .i_src   (w_lane_src[g]),
            .i_dst   (r_dst[g]),
            .i_alpha (r_alpha),
            .i_inv   (r_inv),
            .o_num   (w_num[g])
        );

        rbl_to_byte u_to_byte (
            .i_clk    (i_clk),
            .i_en_mul (w_en[3]),
            .i_en_fix (w_en[4]),
            .i_x      (w_x[g]),
            .o_byte   (w_byte[g])
        );
    end

    rbl_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en[2]),
        .i_mode (r_mode),
        .i_num  (w_num),
        .o_x    (w_x)
    );

    assign i_pix.ready     = w_en[0];
    assign o_res.valid     = r_valid[NUM_STAGES-1];
    assign o_res.out_red   = w_byte[0];
    assign o_res.out_green = w_byte[1];
    assign o_res.out_blue  = w_byte[2];
    assign o_res.out_alpha = w_byte[3];

endmodule

`default_nettype wire

// ===== hdl/rbl_checker.sv =====
`default_nettype none

module rbl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_red,
    input wire logic [7:0] i_out_green,
    input wire logic [7:0] i_out_blue,
    input wire logic [7:0] i_out_alpha
);

    // A stalled result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_red)
            && $stable(i_out_green) && $stable(i_out_blue) && $stable(i_out_alpha))
        else $error("stalled result changed");

    // The input side is only held off when the whole pipeline backs up.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("request refused without an output stall");

    // A taken output frees the input side in the same cycle.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input not ready while output is ready");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind rgba_pixel_blend_core rbl_checker u_rbl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_red   (o_res.out_red),
    .i_out_green (o_res.out_green),
    .i_out_blue  (o_res.out_blue),
    .i_out_alpha (o_res.out_alpha)
);

`default_nettype wire

// ===== test/rbl_blend_check.sv =====
`default_nettype none

module rbl_blend_check
    import rbl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire t_mode i_cfg_data,
    rbl_in_if         i_pix,
    rbl_out_if        i_res,
    output int        o_errors,
    output int        o_pending
);

    typedef struct packed {
        t_byte red;
        t_byte green;
        t_byte blue;
        t_byte alpha;
    } t_rgba;

    t_mode mode_q;
    t_rgba expected_px_q[$];
    t_rgba want_px;
    int    fail_count = 0;

    assign o_errors = fail_count;

    function automatic t_byte frac_to_byte(input int unsigned num);
        int unsigned full3;
        int unsigned bias;
        int unsigned divisor;
        full3 = FULL3;
        bias = ROUND_BIAS;
        divisor = DIV_D;
        if (num > full3) begin
            num = full3;
        end
        return t_byte'((2 * num + bias) / divisor);
    endfunction

    function automatic t_rgba blend_pixel(input t_mode mode,
                                          input t_byte sr, input t_byte sg,
                                          input t_byte sb, input t_byte sa,
                                          input t_byte cov, input t_byte dr,
                                          input t_byte dg, input t_byte db,
                                          input t_byte da);
        int unsigned full2;
        int unsigned full3;
        int unsigned a;
        int unsigned inv;
        int unsigned nr;
        int unsigned ng;
        int unsigned nb;
        int unsigned na;
        int unsigned peak;
        t_rgba px;
        full2 = FULL2;
        full3 = FULL3;
        a = 32'(sa) * 32'(cov);
        inv = full2 - a;
        if (a == 0 && mode != MODE_ADD) begin
            px = '{dr, dg, db, da};
            return px;
        end
        case (mode)
            MODE_ADD: begin
                nr = 32'(dr) * full2 + 32'(sr) * a;
                ng = 32'(dg) * full2 + 32'(sg) * a;
                nb = 32'(db) * full2 + 32'(sb) * a;
                na = 32'(da) * full2;
                peak = (nr > ng) ? nr : ng;
                peak = (peak > nb) ? peak : nb;
                if (na < peak) begin
                    na = (peak > full3) ? full3 : peak;
                end
            end
            MODE_ERASE: begin
                nr = 32'(dr) * inv;
                ng = 32'(dg) * inv;
                nb = 32'(db) * inv;
                na = 32'(da) * inv;
            end
            default: begin
                nr = 32'(sr) * a + 32'(dr) * inv;
                ng = 32'(sg) * a + 32'(dg) * inv;
                nb = 32'(sb) * a + 32'(db) * inv;
                na = a * 255 + 32'(da) * inv;
            end
        endcase
        px = '{frac_to_byte(nr), frac_to_byte(ng), frac_to_byte(nb), frac_to_byte(na)};
        return px;
    endfunction

    task automatic check_byte(input string field, input t_byte want, input t_byte got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q <= MODE_OVER;
        end else begin
            if (i_cfg_we) begin
                mode_q <= i_cfg_data;
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_px_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    want_px = expected_px_q.pop_front();
                    check_byte("out_red", want_px.red, i_res.out_red);
                    check_byte("out_green", want_px.green, i_res.out_green);
                    check_byte("out_blue", want_px.blue, i_res.out_blue);
                    check_byte("out_alpha", want_px.alpha, i_res.out_alpha);
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                expected_px_q.push_back(blend_pixel(mode_q,
                    i_pix.src_red, i_pix.src_green, i_pix.src_blue, i_pix.src_alpha,
                    i_pix.coverage, i_pix.dst_red, i_pix.dst_green, i_pix.dst_blue,
                    i_pix.dst_alpha));
            end
        end
        o_pending <= expected_px_q.size();
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
    import rbl_pkg::*;

    localparam t_mode MODE_UNUSED = 2'd3;
    localparam int    CYCLE_LIMIT = 200000;
    localparam int    PHASE_ITEMS = 100;
    localparam int    NUM_PHASES = 8;
    localparam int    NUM_DIRECTED = 6;

    typedef struct packed {
        t_byte sr;
        t_byte sg;
        t_byte sb;
        t_byte sa;
        t_byte cov;
        t_byte dr;
        t_byte dg;
        t_byte db;
        t_byte da;
    } t_blend_req;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_mode i_cfg_data;
    int    errors;
    int    pending;
    int    cycles = 0;
    int    stall_left = 0;
    bit    noisy = 1'b0;

    t_blend_req directed_reqs[NUM_DIRECTED];
    t_mode      directed_modes[4];
    t_mode      phase_modes[NUM_PHASES];

    rbl_in_if  pix ();
    rbl_out_if res ();

    rgba_pixel_blend_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    rbl_blend_check check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .i_res      (res),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            res.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (noisy && $urandom_range(0, 5) == 0) begin
            res.ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            res.ready <= 1'b1;
        end
    end

    function automatic t_byte pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_blend_req random_req();
        t_blend_req r;
        r = '{pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
              pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        return r;
    endfunction

    task automatic send_req(input t_blend_req r);
        if (noisy && $urandom_range(0, 3) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.src_red   <= r.sr;
        pix.src_green <= r.sg;
        pix.src_blue  <= r.sb;
        pix.src_alpha <= r.sa;
        pix.coverage  <= r.cov;
        pix.dst_red   <= r.dr;
        pix.dst_green <= r.dg;
        pix.dst_blue  <= r.db;
        pix.dst_alpha <= r.da;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // The mode is only changed once every outstanding request has completed.
    task automatic set_mode(input t_mode m);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        directed_reqs[0] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        directed_reqs[1] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                             8'd255, 8'd255, 8'd255, 8'd255};
        directed_reqs[2] = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd255,
                             8'd10, 8'd20, 8'd30, 8'd40};
        directed_reqs[3] = '{8'd90, 8'd60, 8'd30, 8'd255, 8'd0,
                             8'd200, 8'd100, 8'd50, 8'd255};
        directed_reqs[4] = '{8'd200, 8'd255, 8'd1, 8'd255, 8'd255,
                             8'd200, 8'd10, 8'd255, 8'd3};
        directed_reqs[5] = '{8'd127, 8'd128, 8'd129, 8'd128, 8'd128,
                             8'd128, 8'd127, 8'd0, 8'd200};
        directed_modes = '{MODE_OVER, MODE_ADD, MODE_ERASE, MODE_UNUSED};
        phase_modes = '{MODE_OVER, MODE_ADD, MODE_ERASE, MODE_UNUSED,
                        MODE_ADD, MODE_OVER, MODE_ERASE, MODE_OVER};

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= MODE_OVER;
        pix.valid     <= 1'b0;
        pix.src_red   <= 8'd0;
        pix.src_green <= 8'd0;
        pix.src_blue  <= 8'd0;
        pix.src_alpha <= 8'd0;
        pix.coverage  <= 8'd0;
        pix.dst_red   <= 8'd0;
        pix.dst_green <= 8'd0;
        pix.dst_blue  <= 8'd0;
        pix.dst_alpha <= 8'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        noisy = 1'b1;
        foreach (directed_modes[m]) begin
            set_mode(directed_modes[m]);
            foreach (directed_reqs[k]) begin
                send_req(directed_reqs[k]);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            noisy = (ph < 6) && (ph % 3 != 2);
            set_mode(phase_modes[ph]);
            repeat (PHASE_ITEMS) send_req(random_req());
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/rbl_pkg.sv
hdl/rbl_if.sv
hdl/rbl_lane.sv
hdl/rbl_merge.sv
hdl/rbl_to_byte.sv
hdl/rgba_pixel_blend_core.sv
hdl/rbl_checker.sv
test/rbl_blend_check.sv
test/tb.sv
